FILE: rtl/core/b3h_pkg.sv
// Shared types, constants and the mixing function for the truncated BLAKE3 unit.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package b3h_pkg;

   // Basic word and block types.
   typedef logic [31:0] word_type;
   typedef word_type [15:0] block_type;
   typedef logic [3:0] idx_type;

   // One request as it arrives on the input channel.
   typedef struct packed {
      logic [63:0] msg_word0;
      logic [63:0] msg_word1;
      logic [63:0] msg_word2;
      logic [63:0] msg_word3;
      logic [63:0] msg_word4;
      logic [63:0] msg_word5;
      logic [63:0] msg_word6;
      logic [63:0] msg_word7;
      logic [6:0]  byte_length;
   } req_type;

   // One result as it leaves on the output channel.
   typedef struct packed {
      logic [63:0] digest_low;
      logic [63:0] digest_high;
      logic        too_long;
   } rsp_type;

   // Payload carried from stage to stage: working state and message words.
   typedef struct packed {
      logic      too_long;
      block_type v;
      block_type m;
   } stage_type;

   // Four state words that one mixing step works on.
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quad_type;

   localparam int ROUNDS = 7;
   localparam logic [6:0] MAX_LEN = 7'd64;
   localparam word_type BLOCK_FLAGS = 32'd11;  // chunk start, chunk end and root

   localparam word_type IV [8] = '{
      32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
      32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

   localparam idx_type PERM [16] = '{
      4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
      4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8};

   // The quarter-round mixing function with its four fixed rotations.
   function automatic quad_type g_mix(input quad_type q, input word_type x,
                                      input word_type y);
      quad_type r;
      word_type t;
      r = q;
      r.a = r.a + r.b + x;
      t = r.d ^ r.a;
      r.d = {t[15:0], t[31:16]};
      r.c = r.c + r.d;
      t = r.b ^ r.c;
      r.b = {t[11:0], t[31:12]};
      r.a = r.a + r.b + y;
      t = r.d ^ r.a;
      r.d = {t[7:0], t[31:8]};
      r.c = r.c + r.d;
      t = r.b ^ r.c;
      r.b = {t[6:0], t[31:7]};
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/blake3_single_block_hash128_unit.sv
// Top level of the single-block BLAKE3 unit with a 128-bit truncated digest.
// Depends on b3h_pkg, b3h_prep and b3h_round.
// Stages from an accepted request to a valid result: one input stage, two
// stages per round for seven rounds, one output stage.
// Throughput: one request per cycle while rsp_stall is low; every stage holds its own valid bit.
// Reset clears only the valid bits; the pipeline is empty right after it.
`timescale 1ns / 1ps
`default_nettype none

module blake3_single_block_hash128_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire b3h_pkg::req_type req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output b3h_pkg::rsp_type      rsp_data,
   input  wire logic             rsp_stall
);

   logic               stg_valid [b3h_pkg::ROUNDS + 1];
   b3h_pkg::stage_type stg_data  [b3h_pkg::ROUNDS + 1];
   logic               stg_ready [b3h_pkg::ROUNDS + 1];
   logic               prep_ready;
   logic               out_ready;
   logic               rsp_valid_ff;
   b3h_pkg::rsp_type   rsp_data_ff;
   b3h_pkg::rsp_type   rsp_data_in;
   b3h_pkg::stage_type fin;

   assign req_stall = !prep_ready;

   // Masking and state setup.
   b3h_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .in_ready  (prep_ready),
      .out_valid (stg_valid[0]),
      .out_data  (stg_data[0]),
      .out_ready (stg_ready[0])
   );

   // Seven rounds in a chain.
   for (genvar r = 0; r < b3h_pkg::ROUNDS; r++) begin : g_round
      b3h_round u_round (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[r]),
         .in_data   (stg_data[r]),
         .in_ready  (stg_ready[r]),
         .out_valid (stg_valid[r + 1]),
         .out_data  (stg_data[r + 1]),
         .out_ready (stg_ready[r + 1])
      );
   end

   // Output register: fold the halves of the state, zero an overlong request.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign stg_ready[b3h_pkg::ROUNDS] = out_ready;
   assign fin = stg_data[b3h_pkg::ROUNDS];

   always_comb begin
      rsp_data_in.too_long = fin.too_long;
      if (fin.too_long) begin
         rsp_data_in.digest_low  = '0;
         rsp_data_in.digest_high = '0;
      end else begin
         rsp_data_in.digest_low  = {fin.v[1] ^ fin.v[9], fin.v[0] ^ fin.v[8]};
         rsp_data_in.digest_high = {fin.v[3] ^ fin.v[11], fin.v[2] ^ fin.v[10]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= stg_valid[b3h_pkg::ROUNDS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && stg_valid[b3h_pkg::ROUNDS]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/b3h_prep.sv
// Input stage: masks bytes past the length and loads the initial state.
// Depends on b3h_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b3h_prep (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire b3h_pkg::req_type   in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output b3h_pkg::stage_type      out_data,
   input  wire logic               out_ready
);

   logic               valid_ff;
   b3h_pkg::stage_type data_ff;
   b3h_pkg::stage_type data_in;
   logic [511:0]       raw;
   logic [511:0]       masked;

   // The stage moves when it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;

   // Zero every byte at or past the length, then build the start state.
   always_comb begin
      raw = {in_data.msg_word7, in_data.msg_word6, in_data.msg_word5,
             in_data.msg_word4, in_data.msg_word3, in_data.msg_word2,
             in_data.msg_word1, in_data.msg_word0};
      for (int j = 0; j < 64; j++) begin
         masked[8*j +: 8] = (7'(j) < in_data.byte_length) ? raw[8*j +: 8] : 8'd0;
      end
      data_in.too_long = in_data.byte_length > b3h_pkg::MAX_LEN;
      data_in.m = b3h_pkg::block_type'(masked);
      for (int k = 0; k < 8; k++) begin
         data_in.v[k] = b3h_pkg::IV[k];
      end
      for (int k = 0; k < 4; k++) begin
         data_in.v[8 + k] = b3h_pkg::IV[k];
      end
      data_in.v[12] = '0;
      data_in.v[13] = '0;
      data_in.v[14] = {25'd0, in_data.byte_length};
      data_in.v[15] = b3h_pkg::BLOCK_FLAGS;
   end

   // Valid bit, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Payload register.
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/b3h_round.sv
// One compression round as two register stages: column mix, then diagonal
// mix with the message permutation. Depends on b3h_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b3h_round (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire b3h_pkg::stage_type in_data,
   output logic                    in_ready,
   output logic                    out_valid,
   output b3h_pkg::stage_type      out_data,
   input  wire logic               out_ready
);

   logic               col_valid_ff;
   b3h_pkg::stage_type col_ff;
   b3h_pkg::stage_type col_in;
   logic               diag_valid_ff;
   b3h_pkg::stage_type diag_ff;
   b3h_pkg::stage_type diag_in;
   logic               col_ready;
   logic               diag_ready;
   b3h_pkg::quad_type  cq;
   b3h_pkg::quad_type  dq;

   // Each stage moves when it is empty or its content moves on.
   assign diag_ready = !diag_valid_ff || out_ready;
   assign col_ready  = !col_valid_ff || diag_ready;
   assign in_ready   = col_ready;

   // Column step: four independent mixes on the columns of the state.
   always_comb begin
      col_in = in_data;
      for (int i = 0; i < 4; i++) begin
         cq = b3h_pkg::g_mix({in_data.v[i], in_data.v[i + 4], in_data.v[i + 8],
                              in_data.v[i + 12]},
                             in_data.m[2*i], in_data.m[2*i + 1]);
         col_in.v[i]      = cq.a;
         col_in.v[i + 4]  = cq.b;
         col_in.v[i + 8]  = cq.c;
         col_in.v[i + 12] = cq.d;
      end
   end

   // Diagonal step, then the message words are permuted for the next round.
   always_comb begin
      diag_in = col_ff;
      for (int i = 0; i < 4; i++) begin
         dq = b3h_pkg::g_mix({col_ff.v[i], col_ff.v[4 + ((i + 1) % 4)],
                              col_ff.v[8 + ((i + 2) % 4)], col_ff.v[12 + ((i + 3) % 4)]},
                             col_ff.m[8 + 2*i], col_ff.m[9 + 2*i]);
         diag_in.v[i]                 = dq.a;
         diag_in.v[4 + ((i + 1) % 4)]  = dq.b;
         diag_in.v[8 + ((i + 2) % 4)]  = dq.c;
         diag_in.v[12 + ((i + 3) % 4)] = dq.d;
      end
      for (int k = 0; k < 16; k++) begin
         diag_in.m[k] = col_ff.m[b3h_pkg::PERM[k]];
      end
   end

   // Valid bits, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_valid_ff  <= 1'b0;
         diag_valid_ff <= 1'b0;
      end else begin
         if (col_ready) begin
            col_valid_ff <= in_valid;
         end
         if (diag_ready) begin
            diag_valid_ff <= col_valid_ff;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (col_ready && in_valid) begin
         col_ff <= col_in;
      end
      if (diag_ready && col_valid_ff) begin
         diag_ff <= diag_in;
      end
   end

   assign out_valid = diag_valid_ff;
   assign out_data  = diag_ff;

endmodule

`default_nettype wire
